// ===== rtl/tzsr_pkg.sv =====
package tzsr_pkg;

  localparam int ScreenW = 320;
  localparam int ScreenH = 240;
  localparam int MapSize = 256;

  typedef enum logic [2:0] {
    FuncLoadTexel = 3'd0,
    FuncFirstEnd  = 3'd1,
    FuncSecondEnd = 3'd2,
    FuncStep      = 3'd3,
    FuncClear     = 3'd4
  } func_e;

  localparam int NumLanes = 5;

endpackage

// ===== rtl/textured_zbuffer_span_raster.sv =====
// Textured, depth-buffered horizontal span rasterizer.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// load texel, first endpoint, second endpoint (starts a span), step, clear depth.
// Output channel (out_valid_o / out_stall_i) carries one pixel result per step.
// Commands are taken one at a time; in_stall_o is high while one is at work.
// Load texel, first endpoint and a rejected span finish in the idle state; clear depth
// writes its entry in StClrWr.  Second endpoint runs five restoring divisions of 33-bit
// differences by the span width in one shared subtract/shift unit, one
// quotient bit per cycle.  A step passes StStepRd (registered reads of the
// depth and texture memories, the light multiply), StStepMul (depth write) and
// StStepOut (result registered); a step with no span goes straight to StOutWait.
// A result holds in its output register while out_stall_i is high and the
// next command is not taken until it leaves.
// At reset the depth store is cleared to 0xFFFF by a pass over all of its
// entries, one entry per cycle, during which no command is taken.
// The texture store has no reset and must be loaded before it is sampled.
module textured_zbuffer_span_raster #(
  parameter int SCREEN_W = tzsr_pkg::ScreenW,
  parameter int SCREEN_H = tzsr_pkg::ScreenH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [7:0]         row_i,
  input  logic signed [15:0] column_i,
  input  logic [15:0]        depth_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  input  logic signed [31:0] env_u_i,
  input  logic signed [31:0] env_v_i,
  input  logic [15:0]        texel_index_i,
  input  logic [23:0]        texel_rgb_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         pixel_row_o,
  output logic [8:0]         pixel_column_o,
  output logic [23:0]        pixel_color_o,
  output logic               pixel_written_o,
  output logic               span_last_o
);
  import tzsr_pkg::*;

  localparam int Depth = SCREEN_W * SCREEN_H;
  localparam int AW = $clog2(Depth);

  typedef enum logic [3:0] {
    StClear, StIdle, StDivSetup, StDiv, StDivNext, StStepRd, StStepMul,
    StStepOut, StClrWr, StOutWait
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;

  // memories
  logic [23:0] tex_mem [MapSize*MapSize];
  logic [15:0] z_mem [Depth];
  logic [23:0] tex_rd_q;
  logic [15:0] z_rd_q;
  logic        z_we;
  logic [AW-1:0] z_wa, z_ra;
  logic [15:0] z_wd;

  // endpoint and span state
  logic signed [15:0] a_col_q;
  logic signed [31:0] fe_q [NumLanes];
  logic signed [31:0] sec_q [NumLanes];
  logic [31:0] interp_q [NumLanes];
  logic [31:0] inc_q [NumLanes];
  logic signed [16:0] cur_q, end_q;
  logic [7:0]  srow_q;
  logic        active_q;
  logic [AW-1:0] offs_q;

  // shared divider
  logic [2:0]  lane_q;
  logic [5:0]  bit_q;
  logic [32:0] dnum_q, quot_q;
  logic [33:0] rem_q;
  logic [16:0] dx_q;
  logic        dneg_q;
  logic        swap_q;

  // step pipeline
  logic [15:0] dist_q;
  logic        pass_q, onscr_q;
  logic        z_pass;

  logic [2:0]  func_e_w;
  assign func_e_w = func_i;

  logic in_fire;
  assign in_stall_o = (state_q != StIdle);
  assign in_fire = in_valid_i && !in_stall_o;

  logic [31:0] in_lane [NumLanes];
  assign in_lane[0] = {16'd0, depth_i};
  assign in_lane[1] = tex_u_i;
  assign in_lane[2] = tex_v_i;
  assign in_lane[3] = env_u_i;
  assign in_lane[4] = env_v_i;

  // divider subtract
  logic [33:0] rem_sh;
  logic [34:0] rem_try;
  assign rem_sh = {rem_q[32:0], dnum_q[32]};
  assign rem_try = {1'b0, rem_sh} - {18'd0, dx_q};

  // light value: distance squared over 35 by a reciprocal multiply, clamped to 255
  logic [7:0] lu, lv;
  logic signed [8:0] da, db;
  assign lu = interp_q[3][23:16];
  assign lv = interp_q[4][23:16];
  assign da = 9'sd128 - $signed({1'b0, lu});
  assign db = 9'sd128 - $signed({1'b0, lv});
  logic [30:0] recip;
  logic [15:0] cq;
  logic [7:0]  lf;
  // dist/35 = (dist*59919)>>21 exact for dist <= 32768
  assign recip = {15'd0, dist_q} * 31'd59919;
  assign cq = {5'd0, recip[30:21] > 10'd255 ? 11'd255 : {1'b0, recip[30:21]}};
  assign lf = 8'd255 - cq[7:0];

  // depth test on the registered depth read
  assign z_pass = onscr_q && (interp_q[0][31] || interp_q[0] < {16'd0, z_rd_q});

  function automatic logic [7:0] sat_add(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // depth memory port
  always_comb begin
    z_we = 1'b0;
    z_wa = offs_q;
    z_wd = interp_q[0][15:0];
    if (state_q == StClear) begin
      z_we = 1'b1;
      z_wa = clr_q;
      z_wd = 16'hFFFF;
    end else if (state_q == StClrWr) begin
      z_we = 1'b1;
      z_wd = 16'hFFFF;
    end else if (state_q == StStepMul) begin
      z_we = z_pass;
    end
  end
  assign z_ra = offs_q;

  always_ff @(posedge clk_i) begin
    if (z_we) z_mem[z_wa] <= z_wd;
    z_rd_q <= z_mem[z_ra];
    if (in_fire && func_e_w == FuncLoadTexel) tex_mem[texel_index_i] <= texel_rgb_i;
    tex_rd_q <= tex_mem[{interp_q[2][23:16], interp_q[1][23:16]}];
  end

  logic signed [16:0] col_s;
  assign col_s = {column_i[15], column_i};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      active_q <= 1'b0;
      out_valid_o <= 1'b0;
      a_col_q <= '0;
      cur_q <= '0;
      end_q <= '0;
      srow_q <= '0;
      lane_q <= '0;
      bit_q <= '0;
      for (int k = 0; k < NumLanes; k++) begin
        fe_q[k] <= '0;
        interp_q[k] <= '0;
        inc_q[k] <= '0;
      end
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Depth - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_fire) begin
            case (func_i)
              FuncFirstEnd: begin
                a_col_q <= column_i;
                for (int k = 0; k < NumLanes; k++) fe_q[k] <= in_lane[k];
              end
              FuncSecondEnd: begin
                active_q <= 1'b0;
                swap_q <= $signed(a_col_q) > column_i;
                for (int k = 0; k < NumLanes; k++) sec_q[k] <= in_lane[k];
                if ($signed(a_col_q) > column_i) begin
                  cur_q <= col_s;
                  end_q <= {a_col_q[15], a_col_q};
                  dx_q <= 17'({a_col_q[15], a_col_q} - col_s);
                end else begin
                  cur_q <= {a_col_q[15], a_col_q};
                  end_q <= col_s;
                  dx_q <= 17'(col_s - {a_col_q[15], a_col_q});
                end
                srow_q <= row_i;
                if ({24'd0, row_i} < SCREEN_H && a_col_q != column_i &&
                    (($signed(a_col_q) > column_i) ?
                      (col_s <= 17'(SCREEN_W - 1) && a_col_q[15] == 1'b0) :
                      ($signed({a_col_q[15], a_col_q}) <= 17'(SCREEN_W - 1) &&
                       column_i[15] == 1'b0))) begin
                  lane_q <= '0;
                  state_q <= StDivSetup;
                end
              end
              FuncStep: begin
                if (active_q) begin
                  onscr_q <= !cur_q[16] && cur_q < 17'(SCREEN_W);
                  offs_q <= AW'({24'd0, srow_q} * SCREEN_W + int'(cur_q[15:0]));
                  state_q <= StStepRd;
                end else begin
                  pixel_row_o <= '0;
                  pixel_column_o <= '0;
                  pixel_color_o <= '0;
                  pixel_written_o <= 1'b0;
                  span_last_o <= 1'b1;
                  out_valid_o <= 1'b1;
                  state_q <= StOutWait;
                end
              end
              FuncClear: begin
                offs_q <= AW'({24'd0, row_i} * SCREEN_W + int'(column_i[15:0]));
                if ({24'd0, row_i} < SCREEN_H && !column_i[15] &&
                    col_s < 17'(SCREEN_W)) state_q <= StClrWr;
              end
              default: ;
            endcase
          end
        end
        StDivSetup: begin
          // signed difference, high end minus low end
          logic signed [32:0] hi, lo, df;
          hi = swap_q ? {fe_q[lane_q][31], fe_q[lane_q]} : {sec_q[lane_q][31], sec_q[lane_q]};
          lo = swap_q ? {sec_q[lane_q][31], sec_q[lane_q]} : {fe_q[lane_q][31], fe_q[lane_q]};
          df = hi - lo;
          interp_q[lane_q] <= lo[31:0];
          dneg_q <= df[32];
          dnum_q <= df[32] ? 33'(-df) : df;
          rem_q <= '0;
          quot_q <= '0;
          bit_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (!rem_try[34]) begin
            rem_q <= rem_try[33:0];
            quot_q <= {quot_q[31:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quot_q <= {quot_q[31:0], 1'b0};
          end
          dnum_q <= {dnum_q[31:0], 1'b0};
          bit_q <= bit_q + 1'b1;
          if (bit_q == 6'd32) state_q <= StDivNext;
        end
        StDivNext: begin
          inc_q[lane_q] <= dneg_q ? 32'(-quot_q) : quot_q[31:0];
          if (lane_q == 3'(NumLanes - 1)) begin
            active_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            lane_q <= lane_q + 1'b1;
            state_q <= StDivSetup;
          end
        end
        StStepRd: begin
          // memories read into their registers here, used from StStepMul
          dist_q <= 16'($signed(da) * $signed(da) + $signed(db) * $signed(db));
          state_q <= StStepMul;
        end
        StStepMul: begin
          pass_q <= z_pass;
          state_q <= StStepOut;
        end
        StStepOut: begin
          pixel_row_o <= srow_q;
          pixel_column_o <= onscr_q ? cur_q[8:0] : 9'd0;
          pixel_written_o <= pass_q;
          pixel_color_o <= pass_q ? {sat_add(tex_rd_q[23:16], lf),
                                     sat_add(tex_rd_q[15:8], lf),
                                     sat_add(tex_rd_q[7:0], lf)} : 24'd0;
          span_last_o <= (cur_q + 17'sd1 >= end_q) ||
                         (cur_q + 17'sd1 > 17'(SCREEN_W - 1));
          if ((cur_q + 17'sd1 >= end_q) || (cur_q + 17'sd1 > 17'(SCREEN_W - 1)))
            active_q <= 1'b0;
          for (int k = 0; k < NumLanes; k++) interp_q[k] <= interp_q[k] + inc_q[k];
          cur_q <= cur_q + 1'b1;
          out_valid_o <= 1'b1;
          state_q <= StOutWait;
        end
        StClrWr: state_q <= StIdle;
        StOutWait: begin
          if (!out_valid_o || !out_stall_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // assertions
  a_no_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_fire) else $error("command taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_idle_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !out_valid_o) else $error("idle with a result pending");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import tzsr_pkg::*;

  typedef struct {
    logic [2:0]         func;
    logic [7:0]         row;
    logic signed [15:0] column;
    logic [15:0]        depth;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] env_u;
    logic signed [31:0] env_v;
    logic [15:0]        texel_index;
    logic [23:0]        texel_rgb;
  } raster_cmd_t;

  typedef struct {
    logic [7:0]  row;
    logic [8:0]  column;
    logic [23:0] color;
    logic        written;
    logic        last;
  } pixel_t;

  localparam int IdleLimit = 300000;
  localparam logic [2:0] FuncBad5 = 3'd5;
  localparam logic [2:0] FuncBad7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] func_i = '0;
  logic [7:0] row_i = '0;
  logic signed [15:0] column_i = '0;
  logic [15:0] depth_i = '0;
  logic signed [31:0] tex_u_i = '0, tex_v_i = '0, env_u_i = '0, env_v_i = '0;
  logic [15:0] texel_index_i = '0;
  logic [23:0] texel_rgb_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] pixel_row_o;
  logic [8:0] pixel_column_o;
  logic [23:0] pixel_color_o;
  logic pixel_written_o;
  logic span_last_o;

  textured_zbuffer_span_raster dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the rasterizer
  logic [23:0] texel_mem [MapSize*MapSize];
  bit          texel_loaded [MapSize*MapSize];
  logic [15:0] zbuf [ScreenW*ScreenH];
  longint      first_pt [6];
  int          cur_col, end_col, span_row;
  bit [31:0]   interp [NumLanes];
  bit [31:0]   incr [NumLanes];
  bit          span_on;

  raster_cmd_t cmd_q [$];
  pixel_t      pixel_q [$];
  int          n_items, n_pixels, n_written, n_errors;

  function automatic int light_level(int i, int j);
    int a, b, c;
    a = 128 - i;
    b = 128 - j;
    c = (a * a + b * b) / 35;
    if (c > 255) c = 255;
    return 255 - c;
  endfunction

  function automatic void end_point(input raster_cmd_t c, output longint e [6]);
    e[0] = longint'(c.column);
    e[1] = longint'({16'd0, c.depth});
    e[2] = longint'(c.tex_u);
    e[3] = longint'(c.tex_v);
    e[4] = longint'(c.env_u);
    e[5] = longint'(c.env_v);
  endfunction

  // model one command; predicted pixel goes on pixel_q
  task automatic rasterize(input raster_cmd_t c);
    longint sec [6];
    longint lo [6];
    longint hi [6];
    longint dx;
    pixel_t p;
    int offs, r, g, bl, lf;
    logic [23:0] tx;
    case (c.func)
      FuncLoadTexel: begin
        texel_mem[c.texel_index] = c.texel_rgb;
        texel_loaded[c.texel_index] = 1'b1;
      end
      FuncFirstEnd: end_point(c, first_pt);
      FuncSecondEnd: begin
        end_point(c, sec);
        if (first_pt[0] > sec[0]) begin
          lo = sec;
          hi = first_pt;
        end else begin
          lo = first_pt;
          hi = sec;
        end
        span_on = 1'b0;
        if (!(c.row >= ScreenH || lo[0] > ScreenW - 1 || hi[0] < 0 || lo[0] == hi[0])) begin
          dx = hi[0] - lo[0];
          for (int k = 0; k < NumLanes; k++) begin
            interp[k] = lo[k+1][31:0];
            incr[k] = 32'((hi[k+1] - lo[k+1]) / dx);
          end
          cur_col = int'(lo[0]);
          end_col = int'(hi[0]);
          span_row = c.row;
          span_on = 1'b1;
        end
      end
      FuncStep: begin
        p = '{row: 0, column: 0, color: 0, written: 0, last: 1};
        if (span_on) begin
          p.row = span_row[7:0];
          if (cur_col >= 0 && cur_col < ScreenW) begin
            offs = span_row * ScreenW + cur_col;
            p.column = cur_col[8:0];
            if (interp[0][31] || interp[0] < {16'd0, zbuf[offs]}) begin
              tx = texel_mem[{interp[2][23:16], interp[1][23:16]}];
              lf = light_level(interp[3][23:16], interp[4][23:16]);
              r = tx[23:16] + lf;
              g = tx[15:8] + lf;
              bl = tx[7:0] + lf;
              if (r > 255) r = 255;
              if (g > 255) g = 255;
              if (bl > 255) bl = 255;
              p.color = {r[7:0], g[7:0], bl[7:0]};
              p.written = 1'b1;
              zbuf[offs] = interp[0][15:0];
            end
          end
          for (int k = 0; k < NumLanes; k++) interp[k] += incr[k];
          cur_col++;
          p.last = (cur_col >= end_col || cur_col > ScreenW - 1);
          if (p.last) span_on = 1'b0;
        end
        pixel_q.push_back(p);
      end
      FuncClear: begin
        if (c.row < ScreenH && c.column >= 0 && c.column < ScreenW)
          zbuf[c.row * ScreenW + c.column] = 16'hFFFF;
      end
      default: ;
    endcase
  endtask

  task automatic send(input raster_cmd_t c);
    rasterize(c);
    cmd_q.push_back(c);
    n_items++;
  endtask

  function automatic raster_cmd_t blank(logic [2:0] f);
    raster_cmd_t c;
    c = '{func: f, row: $urandom, column: $urandom, depth: $urandom, tex_u: $urandom,
          tex_v: $urandom, env_u: $urandom, env_v: $urandom, texel_index: $urandom,
          texel_rgb: $urandom};
    return c;
  endfunction

  task automatic send_texel(input logic [15:0] idx, input logic [23:0] rgb);
    raster_cmd_t c;
    c = blank(FuncLoadTexel);
    c.texel_index = idx;
    c.texel_rgb = rgb;
    send(c);
  endtask

  // a step that would sample a never-loaded texel gets that texel loaded first
  task automatic send_step();
    int offs;
    logic [15:0] idx;
    if (span_on && cur_col >= 0 && cur_col < ScreenW) begin
      offs = span_row * ScreenW + cur_col;
      idx = {interp[2][23:16], interp[1][23:16]};
      if ((interp[0][31] || interp[0] < {16'd0, zbuf[offs]}) && !texel_loaded[idx])
        send_texel(idx, $urandom);
    end
    send(blank(FuncStep));
  endtask

  task automatic send_end(input logic [2:0] f, input int r, input int col,
                          input bit wide);
    raster_cmd_t c;
    c = blank(f);
    c.row = r[7:0];
    c.column = col[15:0];
    if (!wide) begin
      c.tex_u = $urandom_range(0, 32'h00FF_FFFF);
      c.tex_v = $urandom_range(0, 32'h00FF_FFFF);
      c.env_u = $urandom_range(0, 32'h00FF_FFFF);
      c.env_v = $urandom_range(0, 32'h00FF_FFFF);
    end
    send(c);
  endtask

  task automatic send_span(input int r, input int c0, input int c1, input int steps);
    send_end(FuncFirstEnd, r, c0, $urandom_range(0, 1));
    send_end(FuncSecondEnd, r, c1, $urandom_range(0, 1));
    repeat (steps) send_step();
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // command driver
  int  in_gap = 0;
  bit  in_calm = 0;
  always @(posedge clk_i) begin
    raster_cmd_t c;
    if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        func_i <= c.func;
        row_i <= c.row;
        column_i <= c.column;
        depth_i <= c.depth;
        tex_u_i <= c.tex_u;
        tex_v_i <= c.tex_v;
        env_u_i <= c.env_u;
        env_v_i <= c.env_v;
        texel_index_i <= c.texel_index;
        texel_rgb_i <= c.texel_rgb;
        in_valid_i <= 1'b1;
        in_gap <= pick_gap(in_calm);
        if ($urandom_range(0, 149) == 0) in_calm <= !in_calm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall
  int  out_gap = 0;
  bit  out_calm = 0;
  always @(posedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap <= pick_gap(out_calm);
      if ($urandom_range(0, 149) == 0) out_calm <= !out_calm;
    end
  end

  // pixel monitor
  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel transaction row %0d column %0d", pixel_row_o,
               pixel_column_o);
        n_errors++;
      end else begin
        e = pixel_q.pop_front();
        n_pixels++;
        if (e.written) n_written++;
        if (pixel_row_o !== e.row) begin
          $error("pixel_row expected %0d actual %0d", e.row, pixel_row_o);
          n_errors++;
        end
        if (pixel_column_o !== e.column) begin
          $error("pixel_column expected %0d actual %0d", e.column, pixel_column_o);
          n_errors++;
        end
        if (pixel_color_o !== e.color) begin
          $error("pixel_color expected %06h actual %06h", e.color, pixel_color_o);
          n_errors++;
        end
        if (pixel_written_o !== e.written) begin
          $error("pixel_written expected %0d actual %0d", e.written, pixel_written_o);
          n_errors++;
        end
        if (span_last_o !== e.last) begin
          $error("span_last expected %0d actual %0d", e.last, span_last_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d pixels outstanding", pixel_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w, c0, kind;
    raster_cmd_t c;
    for (int i = 0; i < ScreenW * ScreenH; i++) zbuf[i] = 16'hFFFF;
    foreach (first_pt[k]) first_pt[k] = 0;
    cur_col = 0;
    end_col = 0;
    span_row = 0;
    span_on = 0;

    // directed: field extremes and corner cases
    send_texel(16'h0000, 24'h000000);
    send_texel(16'hFFFF, 24'hFFFFFF);
    send_step();                                // step with no span
    c = blank(FuncClear); c.row = 8'd240; c.column = 16'sd5; send(c);
    c = blank(FuncClear); c.row = 8'd3; c.column = -16'sd1; send(c);
    c = blank(FuncClear); c.row = 8'd3; c.column = 16'sd320; send(c);
    send(blank(FuncBad5));
    send(blank(FuncBad7));
    send_span(0, 4, -3, 8);                     // swapped ends, left clipping
    send_span(239, 316, 32767, 5);              // right clipping
    send_span(10, 7, 7, 1);                     // zero width
    send_span(240, 0, 9, 1);                    // off-screen row
    send_span(5, -32768, -1, 1);                // entirely left
    send_span(5, 320, 400, 1);                  // entirely right
    send_span(20, 30, 34, 2);                   // replaced while active
    send_span(20, 30, 34, 4);                   // depth tested where drawn before
    c = blank(FuncClear); c.row = 8'd20; c.column = 16'sd31; send(c);
    send_span(20, 30, 34, 5);

    // random: mostly complete spans, rest noise and broken sequences
    while (n_items < 1800) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
        c0 = ($urandom_range(0, 19) == 0) ? $signed(16'($urandom))
                                          : $urandom_range(0, 340) - 12;
        send_span(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 239),
                  c0, c0 + ($urandom_range(0, 1) ? w : -w),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, w + 2) : w + 1);
      end else if (kind < 78) begin
        send_texel($urandom, $urandom);
      end else if (kind < 86) begin
        c = blank(FuncClear);
        if ($urandom_range(0, 3) != 0) begin
          c.row = $urandom_range(0, 239);
          c.column = $urandom_range(0, 319);
        end
        send(c);
      end else if (kind < 91) begin
        send_step();
      end else if (kind < 95) begin
        send(blank($urandom_range(5, 7)));
      end else begin
        send_end($urandom_range(0, 1) ? FuncFirstEnd : FuncSecondEnd,
                 $urandom_range(0, 239), $urandom_range(0, 330) - 5, 1);
        send_step();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (cmd_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
    repeat (30) @(posedge clk_i);

    $display("%0d commands sent, %0d pixel results checked, %0d drawn", n_items, n_pixels,
             n_written);
    if (n_errors == 0 && pixel_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
